FILE: src/sbfd_pkg.sv
// Shared types and constants for the seven-bit frame decoder.
`default_nettype none
package sbfd_pkg;

	localparam int unsigned MAX_FRAME_BYTES = 1024;
	localparam int unsigned POS_W = $clog2(MAX_FRAME_BYTES + 1);
	localparam int unsigned SYM_W = 8;
	localparam int unsigned IDX_W = 10;
	localparam int unsigned LEN_W = 11;

	localparam logic [SYM_W-1:0] FRAME_START = 8'h82;
	localparam logic [SYM_W-1:0] FRAME_END = 8'h83;

	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_END = 1'b1;

	typedef struct packed {
		logic             kind;
		logic [SYM_W-1:0] data_byte;
		logic [IDX_W-1:0] byte_index;
		logic [LEN_W-1:0] frame_length;
		logic             overflowed;
	} sbfd_result_t;

endpackage
`default_nettype wire

FILE: src/sbfd_in_stage.sv
// Input register: captures one received byte per beat.
`default_nettype none
module sbfd_in_stage (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      load,
	input  wire logic                      advance,
	input  wire logic [sbfd_pkg::SYM_W-1:0] rx_byte,
	output logic                           valid_s1,
	output logic [sbfd_pkg::SYM_W-1:0]     rx_byte_s1
);
	import sbfd_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rx_byte_s1 <= rx_byte;
		end
	end

endmodule
`default_nettype wire

FILE: src/sbfd_core.sv
// Frame state and the single-pass symbol decode.
`default_nettype none
module sbfd_core (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      fire,
	input  wire logic [sbfd_pkg::SYM_W-1:0] sym,
	output logic                           res_valid,
	output sbfd_pkg::sbfd_result_t         res
);
	import sbfd_pkg::*;

	logic [2:0]       bit_phase_q;
	logic [SYM_W-1:0] partial_q;
	logic [POS_W-1:0] position_q;
	logic             overflow_q;

	logic [2:0]       bit_phase_d;
	logic [SYM_W-1:0] partial_d;
	logic [POS_W-1:0] position_d;
	logic             overflow_d;

	logic [3:0]       shamt;
	logic [SYM_W-1:0] sym_shl;
	logic             frame_full;

	assign shamt = 4'd9 - {1'b0, bit_phase_q};
	assign sym_shl = sym << shamt;
	assign frame_full = position_q >= POS_W'(MAX_FRAME_BYTES);

	always_comb begin
		bit_phase_d = bit_phase_q;
		partial_d = partial_q;
		position_d = position_q;
		overflow_d = overflow_q;
		res_valid = 1'b0;
		res = '0;
		priority if (sym == FRAME_START) begin
			bit_phase_d = '0;
			partial_d = '0;
			position_d = '0;
			overflow_d = 1'b0;
		end else if (sym == FRAME_END) begin
			res_valid = 1'b1;
			res.kind = KIND_END;
			res.frame_length = LEN_W'(position_q);
			res.overflowed = overflow_q;
			bit_phase_d = '0;
			partial_d = '0;
			position_d = '0;
			overflow_d = 1'b0;
		end else if (frame_full) begin
			// drop the symbol, remember the loss
			overflow_d = 1'b1;
		end else if (bit_phase_q == 3'd0) begin
			partial_d = {sym[SYM_W-2:0], 1'b0};
			bit_phase_d = 3'd7;
		end else begin
			res_valid = 1'b1;
			res.kind = KIND_DATA;
			res.data_byte = partial_q | (sym >> (bit_phase_q - 3'd1));
			res.byte_index = IDX_W'(position_q);
			partial_d = sym_shl;
			// phase + 7 wraps: one byte completed, phase steps back by one
			bit_phase_d = bit_phase_q - 3'd1;
			position_d = position_q + POS_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_phase_q <= '0;
			partial_q <= '0;
			position_q <= '0;
			overflow_q <= 1'b0;
		end else if (fire) begin
			bit_phase_q <= bit_phase_d;
			partial_q <= partial_d;
			position_q <= position_d;
			overflow_q <= overflow_d;
		end
	end

endmodule
`default_nettype wire

FILE: src/sbfd_out_stage.sv
// Result register: holds one result beat until the consumer takes it.
`default_nettype none
module sbfd_out_stage (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   load,
	input  wire sbfd_pkg::sbfd_result_t res,
	input  wire logic                   out_stall,
	output logic                        out_valid,
	output logic                        out_free,
	output sbfd_pkg::sbfd_result_t      res_q
);
	import sbfd_pkg::*;

	assign out_free = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule
`default_nettype wire

FILE: src/seven_bit_frame_decoder_top.sv
// Top level of the seven-bit frame decoder.
// Unpacks 7-bit symbols into bytes: 0x82 starts a frame, 0x83 ends it with a
// report of its length in whole bytes and an overflow flag, and every other
// byte is a symbol whose completed bytes come out with their index. One beat
// is taken per clock cycle while in_stall is low; a result passes through the input
// register, then the result register. The input register can take one more beat
// while a result waits in the result register; in_stall rises only when both
// registers are full and the consumer stalls. Symbols past the frame limit are
// dropped and flagged in the end report.
`default_nettype none
module seven_bit_frame_decoder_top (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic [sbfd_pkg::SYM_W-1:0] rx_byte,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic                           kind,
	output logic [sbfd_pkg::SYM_W-1:0]     data_byte,
	output logic [sbfd_pkg::IDX_W-1:0]     byte_index,
	output logic [sbfd_pkg::LEN_W-1:0]     frame_length,
	output logic                           overflowed
);
	import sbfd_pkg::*;

	logic             valid_s1;
	logic [SYM_W-1:0] rx_byte_s1;
	logic             out_free;
	logic             fire;
	logic             load_in;
	logic             res_valid;
	sbfd_result_t     res;
	sbfd_result_t     res_q;

	// advance the held beat whenever the result register can take its result
	assign fire = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign load_in = in_valid && !in_stall;

	sbfd_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load_in),
		.advance    (fire),
		.rx_byte    (rx_byte),
		.valid_s1   (valid_s1),
		.rx_byte_s1 (rx_byte_s1)
	);

	sbfd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.sym       (rx_byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	sbfd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire && res_valid),
		.res       (res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_free  (out_free),
		.res_q     (res_q)
	);

	assign kind = res_q.kind;
	assign data_byte = res_q.data_byte;
	assign byte_index = res_q.byte_index;
	assign frame_length = res_q.frame_length;
	assign overflowed = res_q.overflowed;

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while result register could drain");

	a_data_fields_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_DATA |-> frame_length == '0 && !overflowed)
		else $error("data result carries end report fields");

	a_end_fields_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_END |->
			data_byte == '0 && byte_index == '0
			&& frame_length <= LEN_W'(MAX_FRAME_BYTES))
		else $error("end report malformed");

endmodule
`default_nettype wire
